/* src/arfr_pkg.sv */
`timescale 1ns / 1ps
// arfr_pkg: types, codes and prefix tables of the modem reply frame receiver.
// No dependencies; imported by at_reply_frame_receiver.
package arfr_pkg;

    localparam int DEF_BUF_DEPTH = 1024;
    localparam int DEF_TICK_BITS = 16;

    localparam int LIMIT_W  = 16;
    localparam int LEN_W    = 11;
    localparam int POS_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [LEN_W-1:0] ERR_PREFIX_LEN = 11'd7;
    localparam logic [LEN_W-1:0] SMS_PREFIX_LEN = 11'd6;

    localparam logic [LIMIT_W-1:0] GAP_LIMIT_RST  = 16'd2;
    localparam logic [LIMIT_W-1:0] WAIT_LIMIT_RST = 16'd100;
    localparam logic [LEN_W-1:0]   BUF_LEN_RST    = 11'd1024;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_GAP_END   = 3'd0,
        ST_BUF_FULL  = 3'd1,
        ST_NO_REPLY  = 3'd2,
        ST_ERR_REPLY = 3'd3,
        ST_SMS       = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAP_LIMIT  = 2'd0,
        REG_WAIT_LIMIT = 2'd1,
        REG_BUFFER_LEN = 2'd2,
        REG_SMS_CHECK  = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_WAIT = 3'b010,
        PH_RECV = 3'b100
    } t_phase;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic             result_kind;
        logic [7:0]       byte_value;
        logic [POS_W-1:0] position;
        t_status          status;
        logic [LEN_W-1:0] length;
        logic             last;
    } t_out_item;

    // CR LF "ERROR"
    function automatic logic [7:0] err_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h0D;
            3'd1:    v = 8'h0A;
            3'd2:    v = 8'h45;
            3'd3:    v = 8'h52;
            3'd4:    v = 8'h52;
            3'd5:    v = 8'h4F;
            3'd6:    v = 8'h52;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // CR LF "+CMT"
    function automatic logic [7:0] sms_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h0D;
            3'd1:    v = 8'h0A;
            3'd2:    v = 8'h2B;
            3'd3:    v = 8'h43;
            3'd4:    v = 8'h4D;
            3'd5:    v = 8'h54;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

/* src/at_reply_frame_receiver.sv */
`timescale 1ns / 1ps
// at_reply_frame_receiver: frames one modem reply from a byte/tick stream.
// Depends on arfr_pkg.
//
//  channel | direction | handshake               | payload
//  in      | to block  | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  out     | from block| o_out_valid / i_out_stall| o_out_data (t_out_item)
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One input transfer per cycle; its results are queued the next cycle.
// Results go through a 4-entry output queue; input stalls while fewer than two
// entries are free, so one result per item sustains one item per cycle
// while out is not stalled. An item giving two results needs two transfers.
// Synchronous active-low reset; all but the queue storage return to defaults.
// cfg is always ready.
module at_reply_frame_receiver
    import arfr_pkg::*;
#(
    parameter int BUF_DEPTH = DEF_BUF_DEPTH,
    parameter int TICK_BITS = DEF_TICK_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int CMP_W = (TICK_BITS > LIMIT_W) ? TICK_BITS : LIMIT_W;
    localparam logic [LEN_W-1:0] DEPTH_CAP =
        (BUF_DEPTH > 2047) ? 11'd2047 : LEN_W'(BUF_DEPTH);

    logic [LIMIT_W-1:0]   r_gap_limit;
    logic [LIMIT_W-1:0]   r_wait_limit;
    logic [LEN_W-1:0]     r_buffer_len;
    logic                 r_sms_check;

    t_phase               r_phase, n_phase;
    logic [TICK_BITS-1:0] r_idle, n_idle;
    logic [LEN_W-1:0]     r_count, n_count;
    logic                 r_bip, n_bip;
    logic                 r_err_ok, n_err_ok;
    logic                 r_sms_ok, n_sms_ok;

    t_out_item            r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_AW:0]     r_fill;

    t_out_item            res0, res1;
    logic [1:0]           npush;
    logic                 in_xfer, out_xfer;
    logic [LEN_W-1:0]     eff_len;
    logic [LEN_W-1:0]     cnt_inc;
    logic [TICK_BITS-1:0] idle_inc;
    t_reg_idx             cfg_idx;

    assign o_cfg_ready = 1'b1;
    assign cfg_idx     = t_reg_idx'(i_cfg_index);
    assign o_in_stall  = (r_fill > (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign o_out_valid = (r_fill != '0);
    assign o_out_data  = r_fifo[r_rd];
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = o_out_valid && !i_out_stall;
    assign eff_len     = (r_buffer_len < DEPTH_CAP) ? r_buffer_len : DEPTH_CAP;
    assign cnt_inc     = r_count + 11'd1;
    assign idle_inc    = (r_idle == '1) ? r_idle : r_idle + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit  <= GAP_LIMIT_RST;
            r_wait_limit <= WAIT_LIMIT_RST;
            r_buffer_len <= BUF_LEN_RST;
            r_sms_check  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (cfg_idx)
                REG_GAP_LIMIT:  r_gap_limit  <= i_cfg_data;
                REG_WAIT_LIMIT: r_wait_limit <= i_cfg_data;
                REG_BUFFER_LEN: r_buffer_len <= i_cfg_data[LEN_W-1:0];
                REG_SMS_CHECK:  r_sms_check  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_idle   = r_idle;
        n_count  = r_count;
        n_bip    = r_bip;
        n_err_ok = r_err_ok;
        n_sms_ok = r_sms_ok;
        res0     = '0;
        res1     = '0;
        npush    = 2'd0;
        if (in_xfer) begin
            case (i_in_data.opcode)
                OP_START: begin
                    n_phase  = PH_WAIT;
                    n_idle   = '0;
                    n_count  = '0;
                    n_bip    = 1'b0;
                    n_err_ok = 1'b1;
                    n_sms_ok = 1'b1;
                    if (eff_len == '0) begin
                        n_phase          = PH_IDLE;
                        res0.result_kind = KIND_REPORT;
                        res0.status      = ST_BUF_FULL;
                        res0.last        = 1'b1;
                        npush            = 2'd1;
                    end
                end
                OP_BYTE: begin
                    if (r_phase != PH_IDLE) begin
                        if (r_count >= eff_len) begin
                            n_phase          = PH_IDLE;
                            res0.result_kind = KIND_REPORT;
                            res0.status      = ST_BUF_FULL;
                            res0.length      = r_count;
                            res0.last        = 1'b1;
                            npush            = 2'd1;
                        end else begin
                            if (r_count < ERR_PREFIX_LEN &&
                                i_in_data.rx_byte != err_byte(r_count[2:0]))
                                n_err_ok = 1'b0;
                            if (r_count < SMS_PREFIX_LEN &&
                                i_in_data.rx_byte != sms_byte(r_count[2:0]))
                                n_sms_ok = 1'b0;
                            n_count          = cnt_inc;
                            n_bip            = 1'b1;
                            n_idle           = '0;
                            n_phase          = PH_RECV;
                            res0.result_kind = KIND_BYTE;
                            res0.byte_value  = i_in_data.rx_byte;
                            res0.position    = r_count[POS_W-1:0];
                            res1.result_kind = KIND_REPORT;
                            res1.last        = 1'b1;
                            npush            = 2'd2;
                            if (cnt_inc == ERR_PREFIX_LEN && n_err_ok) begin
                                n_phase     = PH_IDLE;
                                res1.status = ST_ERR_REPLY;
                            end else if (cnt_inc == ERR_PREFIX_LEN && r_sms_check &&
                                         n_sms_ok) begin
                                n_phase     = PH_IDLE;
                                res1.status = ST_SMS;
                            end else if (cnt_inc >= eff_len) begin
                                n_phase     = PH_IDLE;
                                res1.status = ST_BUF_FULL;
                                res1.length = cnt_inc;
                            end else begin
                                res0.last = 1'b1;
                                res1      = '0;
                                npush     = 2'd1;
                            end
                        end
                    end
                end
                OP_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        if (r_bip) begin
                            n_bip = 1'b0;
                        end else begin
                            n_idle = idle_inc;
                            if (r_phase == PH_WAIT) begin
                                if (CMP_W'(idle_inc) >= CMP_W'(r_wait_limit)) begin
                                    n_phase          = PH_IDLE;
                                    res0.result_kind = KIND_REPORT;
                                    res0.status      = ST_NO_REPLY;
                                    res0.last        = 1'b1;
                                    npush            = 2'd1;
                                end
                            end else if (CMP_W'(idle_inc) >= CMP_W'(r_gap_limit)) begin
                                n_phase          = PH_IDLE;
                                res0.result_kind = KIND_REPORT;
                                res0.status      = ST_GAP_END;
                                res0.length      = r_count;
                                res0.last        = 1'b1;
                                npush            = 2'd1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_idle   <= '0;
            r_count  <= '0;
            r_bip    <= 1'b0;
            r_err_ok <= 1'b1;
            r_sms_ok <= 1'b1;
            r_wr     <= '0;
            r_rd     <= '0;
            r_fill   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_idle   <= n_idle;
            r_count  <= n_count;
            r_bip    <= n_bip;
            r_err_ok <= n_err_ok;
            r_sms_ok <= n_sms_ok;
            r_wr     <= r_wr + FIFO_AW'(npush);
            r_rd     <= r_rd + FIFO_AW'(out_xfer);
            r_fill   <= r_fill + (FIFO_AW+1)'(npush) - (FIFO_AW+1)'(out_xfer);
        end
    end

    always_ff @(posedge i_clk) begin
        if (npush != 2'd0)
            r_fifo[r_wr] <= res0;
        if (npush == 2'd2)
            r_fifo[r_wr + FIFO_AW'(1)] <= res1;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("output queue overfilled");

    a_room_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> r_fill <= (FIFO_AW+1)'(FIFO_DEPTH - 2))
        else $error("item accepted without room for two results");

    a_report_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == KIND_REPORT |-> o_out_data.last)
        else $error("frame report not marked last");

    a_pair_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == KIND_BYTE && !o_out_data.last
        |-> r_fill >= (FIFO_AW+1)'(2))
        else $error("byte without its report queued behind it");

    a_idle_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && npush != 2'd0 && (npush == 2'd2 || res0.result_kind == KIND_REPORT)
        |=> r_phase == PH_IDLE)
        else $error("frame still active after its report");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for at_reply_frame_receiver, with its own frame predictor,
// directed frame tests, random frames under random idling, and a long receiver hold-off.
// Depends on arfr_pkg and at_reply_frame_receiver.
module testbench;
    import arfr_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_PAD    = 6;
    localparam int TOTAL_ITEMS  = 1750;

    localparam logic [0:6][7:0] ERR_SEQ = {8'h0D, 8'h0A, 8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};
    localparam logic [0:5][7:0] SMS_SEQ = {8'h0D, 8'h0A, 8'h2B, 8'h43, 8'h4D, 8'h54};

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    at_reply_frame_receiver i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // predictor copy of registers and frame state
    logic [LIMIT_W-1:0] gap_cfg;
    logic [LIMIT_W-1:0] wait_cfg;
    logic [LEN_W-1:0]   buf_len_cfg;
    logic               sms_cfg;
    t_phase             rx_phase;
    logic [15:0]        idle_ticks;
    logic [LEN_W-1:0]   byte_count;
    logic               byte_seen;
    logic               err_match;
    logic               sms_match;

    t_out_item pending_results[$];
    t_out_item want;

    int  error_count      = 0;
    int  items_taken      = 0;
    int  frame_items      = 0;
    int  results_checked  = 0;
    int  reports_checked  = 0;
    int  settings_applied = 0;
    int  cycle_count      = 0;
    bit  gap_enable       = 1'b1;
    bit  stall_enable     = 1'b1;
    bit  hold_off_req     = 1'b0;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic void arm_frame();
        rx_phase   = PH_WAIT;
        idle_ticks = '0;
        byte_count = '0;
        byte_seen  = 1'b0;
        err_match  = 1'b1;
        sms_match  = 1'b1;
    endfunction

    function automatic void push_byte(input logic [7:0] v, input logic [LEN_W-1:0] pos,
                                      input logic lst);
        t_out_item r;
        r             = '0;
        r.result_kind = KIND_BYTE;
        r.byte_value  = v;
        r.position    = pos[POS_W-1:0];
        r.status      = ST_GAP_END;
        r.last        = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void push_report(input t_status st, input logic [LEN_W-1:0] len);
        t_out_item r;
        r             = '0;
        r.result_kind = KIND_REPORT;
        r.status      = st;
        r.length      = len;
        r.last        = 1'b1;
        rx_phase      = PH_IDLE;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_frame_results(input t_in_item it);
        logic [LEN_W-1:0] lim;
        logic [LEN_W-1:0] p;
        lim = (buf_len_cfg < 11'd1024) ? buf_len_cfg : 11'd1024;
        if (it.opcode == OP_START) begin
            frame_items++;
            arm_frame();
            if (lim == 0)
                push_report(ST_BUF_FULL, '0);
        end else if (rx_phase != PH_IDLE && it.opcode != OP_NONE) begin
            frame_items++;
            if (it.opcode == OP_BYTE) begin
                p = byte_count;
                if (p >= lim) begin
                    push_report(ST_BUF_FULL, p);
                end else begin
                    if (p < 7 && it.rx_byte != ERR_SEQ[p[2:0]])
                        err_match = 1'b0;
                    if (p < 6 && it.rx_byte != SMS_SEQ[p[2:0]])
                        sms_match = 1'b0;
                    byte_count = p + 1'b1;
                    byte_seen  = 1'b1;
                    idle_ticks = '0;
                    rx_phase   = PH_RECV;
                    if (byte_count == ERR_PREFIX_LEN && err_match) begin
                        push_byte(it.rx_byte, p, 1'b0);
                        push_report(ST_ERR_REPLY, '0);
                    end else if (byte_count == ERR_PREFIX_LEN && sms_cfg && sms_match) begin
                        push_byte(it.rx_byte, p, 1'b0);
                        push_report(ST_SMS, '0);
                    end else if (byte_count >= lim) begin
                        push_byte(it.rx_byte, p, 1'b0);
                        push_report(ST_BUF_FULL, byte_count);
                    end else begin
                        push_byte(it.rx_byte, p, 1'b1);
                    end
                end
            end else if (byte_seen) begin
                byte_seen = 1'b0;
            end else begin
                if (idle_ticks != 16'hFFFF)
                    idle_ticks = idle_ticks + 1'b1;
                if (rx_phase == PH_WAIT) begin
                    if (idle_ticks >= wait_cfg)
                        push_report(ST_NO_REPLY, '0);
                end else if (idle_ticks >= gap_cfg) begin
                    push_report(ST_GAP_END, byte_count);
                end
            end
        end
    endfunction

    task automatic send_item(input t_opcode op, input logic [7:0] b);
        t_in_item it;
        int n;
        it.opcode  = op;
        it.rx_byte = b;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_frame_results(it);
        items_taken++;
        if (gap_enable) begin
            n = idle_gap();
            if (n > 0) begin
                i_in_valid <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(OP_BYTE, s[i]);
    endtask

    task automatic tick_until_frame_ends();
        while (rx_phase != PH_IDLE)
            send_item(OP_TICK, 8'($urandom));
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [CFG_DAT_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_GAP_LIMIT:  gap_cfg     = v;
            REG_WAIT_LIMIT: wait_cfg    = v;
            REG_BUFFER_LEN: buf_len_cfg = v[LEN_W-1:0];
            REG_SMS_CHECK:  sms_cfg     = v[0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [15:0] gap_v, input logic [15:0] wait_v,
                                input logic [15:0] len_v, input logic [15:0] sms_v);
        wait_results_drained();
        cfg_write(REG_GAP_LIMIT, gap_v);
        cfg_write(REG_WAIT_LIMIT, wait_v);
        cfg_write(REG_BUFFER_LEN, len_v);
        cfg_write(REG_SMS_CHECK, sms_v);
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // reset defaults, ignored items, restart
    task automatic test_after_reset();
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_TICK, 8'h00);
        send_item(OP_NONE, 8'hAA);
        send_item(OP_START, 8'h55);
        send_text("\r\nOK");
        send_item(OP_NONE, 8'h0F);
        tick_until_frame_ends();
        send_item(OP_START, 8'h00);
        tick_until_frame_ends();
        send_item(OP_TICK, 8'hF0);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h78);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h79);
        tick_until_frame_ends();
    endtask

    task automatic test_prefixes();
        write_config(16'd2, 16'd100, 16'd1024, 16'd0);
        send_item(OP_START, 8'h00);
        send_text("\r\nERROR");
        send_item(OP_START, 8'h00);
        send_text("\r\n+CMTI");
        tick_until_frame_ends();
        write_config(16'd2, 16'd100, 16'd1024, 16'd1);
        send_item(OP_START, 8'h00);
        send_text("\r\n+CMTI");
        send_item(OP_START, 8'h00);
        send_text("\r\nERROS");
        tick_until_frame_ends();
        // prefix spread over poll periods
        send_item(OP_START, 8'h00);
        send_text("\r\n+C");
        send_item(OP_TICK, 8'h00);
        send_text("MT:");
        write_config(16'd2, 16'd100, 16'd7, 16'd1);
        send_item(OP_START, 8'h00);
        send_text("\r\nERROR");
        send_item(OP_START, 8'h00);
        send_text("\r\n+CMTX");
        write_config(16'd2, 16'd100, 16'd6, 16'd1);
        send_item(OP_START, 8'h00);
        send_text("\r\n+CMT");
    endtask

    task automatic test_buffer_edges();
        write_config(16'd2, 16'd100, 16'd0, 16'd0);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h41);
        write_config(16'd2, 16'd100, 16'd1, 16'd0);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h41);
        // buffer shrunk under an open frame
        write_config(16'd2, 16'd100, 16'd8, 16'd0);
        send_item(OP_START, 8'h00);
        send_text("abcd");
        write_config(16'd2, 16'd100, 16'd2, 16'd0);
        send_item(OP_BYTE, 8'h65);
    endtask

    task automatic test_zero_limits();
        write_config(16'd0, 16'd0, 16'd1024, 16'd0);
        send_item(OP_START, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h31);
        send_item(OP_BYTE, 8'h32);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'h00);
        write_config(16'd1, 16'd1, 16'd1024, 16'd0);
        send_item(OP_START, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h33);
        tick_until_frame_ends();
    endtask

    task automatic test_limit_extremes();
        write_config(16'hFFFF, 16'hFFFF, 16'd5, 16'd1);
        send_item(OP_START, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_text("AB");
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_text("CDE");
    endtask

    task automatic test_full_buffer();
        int i;
        write_config(16'd2, 16'd3, 16'd1024, 16'd1);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h00);
        for (i = 1; i < 1024; i++)
            send_item(OP_BYTE, 8'($urandom));
        send_item(OP_BYTE, 8'h11);
    endtask

    task automatic test_back_pressure();
        int i;
        write_config(16'd2, 16'd10, 16'd64, 16'd0);
        gap_enable   = 1'b0;
        hold_off_req = 1'b1;
        send_item(OP_START, 8'h00);
        for (i = 0; i < 40; i++)
            send_item(OP_BYTE, 8'(8'h30 + i));
        tick_until_frame_ends();
        gap_enable = 1'b1;
    endtask

    task automatic run_random_frame();
        int i;
        int k;
        int n_bytes;
        int flavor;
        int bad_pos;
        logic [7:0] b;
        if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(1, 3);
            for (i = 0; i < k; i++)
                send_item(t_opcode'($urandom_range(0, 3)), 8'($urandom));
        end
        send_item(OP_START, 8'($urandom));
        k = $urandom_range(0, int'(wait_cfg) + 1);
        for (i = 0; i < k && rx_phase != PH_IDLE; i++)
            send_item(OP_TICK, 8'($urandom));
        flavor  = $urandom_range(0, 9);
        bad_pos = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : 7;
        n_bytes = (flavor < 6) ? $urandom_range(5, 12) : $urandom_range(1, 16);
        if ($urandom_range(0, 19) == 0)
            n_bytes = 30;
        for (i = 0; i < n_bytes && rx_phase != PH_IDLE; i++) begin
            b = 8'($urandom);
            if (flavor < 3 && i < 7)
                b = ERR_SEQ[i];
            else if (flavor < 6 && i < 6)
                b = SMS_SEQ[i];
            if (i == bad_pos)
                b = b ^ 8'($urandom_range(1, 255));
            send_item(OP_BYTE, b);
            if ($urandom_range(0, 4) == 0) begin
                k = $urandom_range(1, int'(gap_cfg) + 1);
                repeat (k) begin
                    if (rx_phase != PH_IDLE)
                        send_item(OP_TICK, 8'($urandom));
                end
            end else if ($urandom_range(0, 29) == 0) begin
                send_item(OP_START, 8'($urandom));
            end
        end
        tick_until_frame_ends();
        if ($urandom_range(0, 7) == 0)
            send_item(t_opcode'($urandom_range(1, 3)), 8'($urandom));
    endtask

    task automatic test_random_frames();
        logic [15:0] gap_v;
        logic [15:0] wait_v;
        logic [15:0] len_v;
        while (items_taken < TOTAL_ITEMS) begin
            case ($urandom_range(0, 4))
                0:       gap_v = 16'd0;
                1:       gap_v = 16'd1;
                default: gap_v = 16'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 3))
                0:       wait_v = 16'd0;
                1:       wait_v = 16'd1;
                default: wait_v = 16'($urandom_range(2, 6));
            endcase
            case ($urandom_range(0, 7))
                0:       len_v = 16'd0;
                1:       len_v = 16'd1;
                2:       len_v = 16'd6;
                3:       len_v = 16'd7;
                4:       len_v = 16'd1024;
                default: len_v = 16'($urandom_range(2, 24));
            endcase
            write_config(gap_v, wait_v, len_v, 16'($urandom_range(0, 1)));
            gap_enable   = ($urandom_range(0, 4) != 0);
            stall_enable = ($urandom_range(0, 4) != 0);
            repeat ($urandom_range(3, 8)) run_random_frame();
        end
        gap_enable   = 1'b1;
        stall_enable = 1'b1;
    endtask

    // receiver side stall generator, with the long hold-off on request
    initial begin : out_stall_gen
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_off_req = 1'b0;
            end else if (stall_enable && $urandom_range(0, 3) == 0) begin
                n = idle_gap() + 1;
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (o_out_data.result_kind == KIND_REPORT)
                reports_checked++;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %p", o_out_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.result_kind !== want.result_kind) begin
                    $error("result_kind mismatch: expected %0d, actual %0d",
                           want.result_kind, o_out_data.result_kind);
                    error_count++;
                end
                if (o_out_data.byte_value !== want.byte_value) begin
                    $error("byte_value mismatch: expected %0d, actual %0d",
                           want.byte_value, o_out_data.byte_value);
                    error_count++;
                end
                if (o_out_data.position !== want.position) begin
                    $error("position mismatch: expected %0d, actual %0d",
                           want.position, o_out_data.position);
                    error_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, o_out_data.status);
                    error_count++;
                end
                if (o_out_data.length !== want.length) begin
                    $error("length mismatch: expected %0d, actual %0d",
                           want.length, o_out_data.length);
                    error_count++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last mismatch: expected %0d, actual %0d",
                           want.last, o_out_data.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        gap_cfg     = GAP_LIMIT_RST;
        wait_cfg    = WAIT_LIMIT_RST;
        buf_len_cfg = BUF_LEN_RST;
        sms_cfg     = 1'b0;
        arm_frame();
        rx_phase = PH_IDLE;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_prefixes();
        test_buffer_edges();
        test_zero_limits();
        test_limit_extremes();
        test_full_buffer();
        test_back_pressure();
        test_random_frames();

        wait_results_drained();
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        $display("Covered %0d input transfers (%0d acting on a frame), %0d register settings.",
                 items_taken, frame_items, settings_applied);
        $display("Checked %0d results, %0d of them frame reports, in %0d cycles.",
                 results_checked, reports_checked, cycle_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
src/arfr_pkg.sv
src/at_reply_frame_receiver.sv
bench/testbench.sv
